/* rtl/tssm_pkg.sv */
// ----------------------------------------------------------------------------
// tssm_pkg
// Shared types and constants for the two-stack shared-memory block.
// ----------------------------------------------------------------------------
package tssm_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = 11;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;
    localparam logic SIDE_LOW  = 1'b0;
    localparam logic SIDE_HIGH = 1'b1;

    typedef struct packed {
        logic accept;
        logic capture_rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic pop_ok;
        logic out_free;
    } t_sts;

endpackage

/* rtl/tssm_if.sv */
// ----------------------------------------------------------------------------
// tssm interfaces
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------
interface tssm_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               side;
    logic signed [31:0] value;

    modport source (output valid, kind, side, value, input ready);
    modport sink   (input valid, kind, side, value, output ready);
endinterface

interface tssm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               all_empty;

    modport source (output valid, result_value, status, all_empty, input ready);
    modport sink   (input valid, result_value, status, all_empty, output ready);
endinterface

interface tssm_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/tssm_ram.sv */
// ----------------------------------------------------------------------------
// tssm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tssm_ctrl.sv */
// ----------------------------------------------------------------------------
// tssm_ctrl
// Sequencer: accept a request, wait for the pop read, hand off the result.
// ----------------------------------------------------------------------------
module tssm_ctrl
    import tssm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.capture_rd = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_sts.pop_ok ? S_RD : S_HOLD;
                end
            end
            S_RD: begin
                o_cmd.capture_rd = 1'b1;
                n_state          = S_HOLD;
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/tssm_dp.sv */
// ----------------------------------------------------------------------------
// tssm_dp
// Datapath: stack counts, capacity, address generation, result registers.
// ----------------------------------------------------------------------------
module tssm_dp
    import tssm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_kind,
    input  logic                  i_side,
    input  logic signed [31:0]    i_value,
    input  logic                  i_cfg_valid,
    input  logic [CNT_W-1:0]      i_cfg_data,
    output logic                  o_ram_we,
    output logic [ADDR_W-1:0]     o_ram_addr,
    output logic [DATA_WIDTH-1:0] o_ram_wdata,
    input  logic [DATA_WIDTH-1:0] i_ram_rdata,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_result_value,
    output logic [ST_W-1:0]       o_status,
    output logic                  o_all_empty
);

    logic [CNT_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_low;
    logic [CNT_W-1:0]   r_high;
    logic [CNT_W-1:0]   n_low;
    logic [CNT_W-1:0]   n_high;
    logic [VAL_W-1:0]   r_pend_val;
    logic [ST_W-1:0]    r_pend_st;
    logic               r_pend_ae;
    logic [VAL_W-1:0]   n_pend_val;
    logic [ST_W-1:0]    n_pend_st;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_val;
    logic [ST_W-1:0]    r_out_st;
    logic               r_out_ae;

    logic [CNT_W-1:0]   eff_cap;
    logic [CNT_W:0]     used;
    logic               full;
    logic [CNT_W-1:0]   addr;
    logic               we;
    logic               pop_ok;

    assign eff_cap = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign used    = {1'b0, r_low} + {1'b0, r_high};
    assign full    = used >= {1'b0, eff_cap};

    always_comb begin
        n_low      = r_low;
        n_high     = r_high;
        n_pend_val = '0;
        n_pend_st  = ST_OK;
        addr       = r_low;
        we         = 1'b0;
        pop_ok     = 1'b0;
        if (i_kind == KIND_PUSH) begin
            if (full) begin
                n_pend_st = ST_FULL;
            end else begin
                we         = 1'b1;
                n_pend_val = VAL_W'(i_value[DATA_WIDTH-1:0]);
                if (i_side == SIDE_HIGH) begin
                    addr   = eff_cap - CNT_W'(1) - r_high;
                    n_high = r_high + CNT_W'(1);
                end else begin
                    addr  = r_low;
                    n_low = r_low + CNT_W'(1);
                end
            end
        end else begin
            if (i_side == SIDE_HIGH) begin
                if (r_high == '0) begin
                    n_pend_st = ST_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    addr   = eff_cap - r_high;
                    n_high = r_high - CNT_W'(1);
                end
            end else begin
                if (r_low == '0) begin
                    n_pend_st = ST_EMPTY;
                end else begin
                    pop_ok = 1'b1;
                    addr   = r_low - CNT_W'(1);
                    n_low  = r_low - CNT_W'(1);
                end
            end
        end
    end

    assign o_ram_we     = i_cmd.accept & we;
    assign o_ram_addr   = addr[ADDR_W-1:0];
    assign o_ram_wdata  = i_value[DATA_WIDTH-1:0];

    assign o_sts.pop_ok   = pop_ok;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap  <= i_cfg_data;
                r_low  <= '0;
                r_high <= '0;
            end else if (i_cmd.accept) begin
                r_low  <= n_low;
                r_high <= n_high;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_val <= n_pend_val;
            r_pend_st  <= n_pend_st;
            r_pend_ae  <= (n_low == '0) && (n_high == '0);
        end else if (i_cmd.capture_rd) begin
            r_pend_val <= VAL_W'(i_ram_rdata);
        end
        if (i_cmd.load_out) begin
            r_out_val <= r_pend_val;
            r_out_st  <= r_pend_st;
            r_out_ae  <= r_pend_ae;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_status       = r_out_st;
    assign o_all_empty    = r_out_ae;

endmodule

/* rtl/two_stacks_shared_memory.sv */
// ----------------------------------------------------------------------------
// two_stacks_shared_memory
// Two stacks in one shared memory; low grows up, high grows down.
//
// Request channel i_in: kind (0 push, 1 pop), side (0 low, 1 high), value.
// Result channel o_out: result_value, status (ok, full, empty), all_empty;
// one result per request, in request order.
// Config channel i_cfg: writes the capacity (saturates at the memory depth)
// and empties both stacks; always ready, write only while no request is open.
// A push or a refused pop goes from idle to the hold state; a good pop
// passes through the read state first, for the registered memory read.
// The hold state loads the result once the output register is free.
// One request at a time: the sequencer returns to idle before the next
// transfer, and a good pop adds the registered memory read.
// A finished result sits in the output register while the next request is
// taken; a stalled receiver holds the following result back and blocks
// further requests until the output register frees.
// Reset: both stacks empty, capacity 1024, memory contents undefined.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory
    import tssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tssm_in_if.sink     i_in,
    tssm_out_if.source  o_out,
    tssm_cfg_if.sink    i_cfg
);

    t_cmd                  w_cmd;
    t_sts                  w_sts;
    logic                  w_ram_we;
    logic [ADDR_W-1:0]     w_ram_addr;
    logic [DATA_WIDTH-1:0] w_ram_wdata;
    logic [DATA_WIDTH-1:0] w_ram_rdata;
    logic                  w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    tssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    tssm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_in.kind),
        .i_side         (i_in.side),
        .i_value        (i_in.value),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .o_ram_we       (w_ram_we),
        .o_ram_addr     (w_ram_addr),
        .o_ram_wdata    (w_ram_wdata),
        .i_ram_rdata    (w_ram_rdata),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_result_value (o_out.result_value),
        .o_status       (o_out.status),
        .o_all_empty    (o_out.all_empty)
    );

    tssm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

endmodule

/* rtl/tssm_chk.sv */
// ----------------------------------------------------------------------------
// tssm_chk
// Port-level checks for two_stacks_shared_memory, bound to the top level.
// ----------------------------------------------------------------------------
module tssm_chk
    import tssm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_result_value,
    input logic [ST_W-1:0]    i_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_value)
            && $stable(i_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status == ST_OK || i_status == ST_FULL
            || i_status == ST_EMPTY)
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_result_value == '0)
        else $error("nonzero value on refused request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is open");

endmodule

bind two_stacks_shared_memory tssm_chk u_tssm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_value (o_out.result_value),
    .i_status       (o_out.status)
);
